/* rtl/core/tcw_pkg.sv */
// Shared types, constants and helpers for the text console writer.
// Used by every module of the block but tcw_ram; depends on nothing else.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_X      = ROW_W + 1;
  localparam int COL_X      = COL_W + 1;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int CELL_W     = 16;

  // Stream word widths
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;

  // Command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);

  // Character codes
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_BLANK    = 8'h20;
  localparam logic [7:0] RESET_COLOR = 8'h07;

  // Operation codes on the input tuser
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Command kinds after classification
  localparam logic [2:0] K_PUT     = 3'd0;
  localparam logic [2:0] K_NEWLINE = 3'd1;
  localparam logic [2:0] K_RETURN  = 3'd2;
  localparam logic [2:0] K_TAB     = 3'd3;
  localparam logic [2:0] K_READ    = 3'd4;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       char_code;
    logic             read_ok;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
  } cmd_t;

  // Back to front status
  typedef struct packed {
    logic pop;
    logic init_busy;
  } back_stat_t;

  // Physical row of a logical row, given the row that is on top of the screen
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_X-1:0] s;
    s = {1'b0, top} + {1'b0, row};
    if (s >= ROW_X'(ROWS)) s = s - ROW_X'(ROWS);
    return s[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

/* rtl/core/tcw_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/tcw_front.sv */
// Front end: accepts input words, classifies them and queues commands.
// Depends on tcw_pkg.
module tcw_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
  input  logic                          s_tuser,
  input  tcw_pkg::back_stat_t           stat,
  output logic                          q_valid,
  output tcw_pkg::cmd_t                 q_cmd
);
  import tcw_pkg::*;

  cmd_t              q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  cmd_t              cmd_in;
  logic              push;
  logic [15:0]       rrow_w;
  logic [15:0]       rcol_w;

  // classify the incoming word
  always_comb begin
    rrow_w = 16'(s_tdata[12:8]);
    rcol_w = 16'(s_tdata[19:13]);
    cmd_in.char_code = s_tdata[7:0];
    cmd_in.read_ok   = (rrow_w < 16'(ROWS)) && (rcol_w < 16'(COLUMNS));
    cmd_in.rd_row    = rrow_w[ROW_W-1:0];
    cmd_in.rd_col    = rcol_w[COL_W-1:0];
    if (s_tuser == OP_READ)               cmd_in.kind = K_READ;
    else if (s_tdata[7:0] == CH_NEWLINE)  cmd_in.kind = K_NEWLINE;
    else if (s_tdata[7:0] == CH_RETURN)   cmd_in.kind = K_RETURN;
    else if (s_tdata[7:0] == CH_TAB)      cmd_in.kind = K_TAB;
    else                                  cmd_in.kind = K_PUT;
  end

  assign s_tready = (count != (QPTR_W+1)'(Q_DEPTH)) && !stat.init_busy;
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_cmd    = q[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cmd_in;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (stat.pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !stat.pop)      count <= count + 1'b1;
      else if (!push && stat.pop) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/tcw_back.sv */
// Back end: executes queued commands on the cursor and the screen memory,
// clears rows and drives the output register. Depends on tcw_pkg, tcw_ram.
module tcw_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  tcw_pkg::cmd_t                 q_cmd,
  output tcw_pkg::back_stat_t           stat,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
  import tcw_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]        state;
  logic [ROW_W-1:0]  top;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [7:0]        text_color;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] clr_last;
  logic [CELL_W-1:0] clr_data;
  logic              clr_res;

  logic              out_free;
  logic              take;
  logic [COL_X-1:0]  adv;
  logic              need_nl;
  logic              last_row;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] top_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  function automatic logic [M_DATA_W-1:0] out_word(input logic [7:0] ch,
                                                   input logic [7:0] co,
                                                   input logic [ROW_W-1:0] r,
                                                   input logic [COL_W-1:0] c,
                                                   input logic s);
    logic [15:0] rw;
    logic [15:0] cw;
    rw = 16'(r);
    cw = 16'(c);
    return {3'b000, s, cw[6:0], rw[4:0], co, ch};
  endfunction

  assign out_free       = !m_tvalid || m_tready;
  assign take           = (state == ST_IDLE) && q_valid && out_free;
  assign stat.pop       = take;
  assign stat.init_busy = (state == ST_CLEAR) && !clr_res;
  assign last_row       = (cur_row == ROW_W'(ROWS - 1));
  assign cur_addr       = cell_addr(phys_row(top, cur_row), cur_col);
  assign top_addr       = cell_addr(top, '0);
  assign ram_raddr      = cell_addr(phys_row(top, q_cmd.rd_row), q_cmd.rd_col);

  // cursor advance per command kind
  always_comb begin
    adv     = {1'b0, cur_col};
    need_nl = 1'b0;
    case (q_cmd.kind)
      K_PUT: begin
        adv     = {1'b0, cur_col} + 1'b1;
        need_nl = (adv >= COL_X'(COLUMNS));
      end
      K_TAB: begin
        adv     = ({1'b0, cur_col} + COL_X'(8)) & ~COL_X'(7);
        need_nl = (adv >= COL_X'(COLUMNS));
      end
      K_NEWLINE: need_nl = 1'b1;
      K_RETURN:  adv     = '0;
      default:   adv     = {1'b0, cur_col};
    endcase
  end

  // memory write port: clearing sweep or a put
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {text_color, q_cmd.char_code};
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = clr_data;
    end else if (take && q_cmd.kind == K_PUT) begin
      ram_we = 1'b1;
    end
  end

  tcw_ram #(.WIDTH(CELL_W), .DEPTH(CELL_COUNT)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer, cursor and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      top        <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= RESET_COLOR;
      clr_addr   <= '0;
      clr_last   <= ADDR_W'(CELL_COUNT - 1);
      clr_data   <= {RESET_COLOR, CH_BLANK};
      clr_res    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (cfg_wr_en) text_color <= cfg_wr_data;
      if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == clr_last) begin
            state <= ST_IDLE;
            if (clr_res) begin
              m_tvalid <= 1'b1;
              m_tdata  <= out_word(8'd0, 8'd0, cur_row, cur_col, 1'b1);
            end
          end
        end
        ST_IDLE: begin
          if (take) begin
            if (q_cmd.kind == K_READ) begin
              if (q_cmd.read_ok) begin
                state <= ST_READ;
              end else begin
                m_tvalid <= 1'b1;
                m_tdata  <= out_word(8'd0, 8'd0, cur_row, cur_col, 1'b0);
              end
            end else if (need_nl) begin
              cur_col <= '0;
              if (last_row) begin
                // scroll: old top row becomes the new bottom row, clear it
                top      <= (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
                clr_addr <= top_addr;
                clr_last <= top_addr + ADDR_W'(COLUMNS - 1);
                clr_data <= {text_color, CH_BLANK};
                clr_res  <= 1'b1;
                state    <= ST_CLEAR;
              end else begin
                cur_row  <= cur_row + 1'b1;
                m_tvalid <= 1'b1;
                m_tdata  <= out_word(8'd0, 8'd0, cur_row + 1'b1, '0, 1'b0);
              end
            end else begin
              cur_col  <= adv[COL_W-1:0];
              m_tvalid <= 1'b1;
              m_tdata  <= out_word(8'd0, 8'd0, cur_row, adv[COL_W-1:0], 1'b0);
            end
          end
        end
        ST_READ: begin
          state    <= ST_IDLE;
          m_tvalid <= 1'b1;
          m_tdata  <= out_word(ram_rdata[7:0], ram_rdata[15:8], cur_row, cur_col,
                               1'b0);
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/text_console_writer.sv */
// Text console writer top level: front classifier/queue plus back executor.
// Depends on tcw_pkg, tcw_front, tcw_back (and tcw_ram inside tcw_back).
//
// Usage:
//  - Input words on s_*: tuser is the operation (put or read), tdata carries
//    the character and the cell address of a read. Each word yields exactly
//    one output word on m_* with the read cell (zero for puts), the cursor
//    after the word and a scroll flag.
//  - cfg_wr_en/cfg_wr_data write the text color; write only while idle.
//  - Path: a put, return, tab or newline without scroll passes the queue,
//    then the executor output register; a read also passes the registered
//    memory read port.
//  - Throughput: the executor takes one non-read word per cycle unless the
//    output stalls; a read also holds it in a read state, and a scroll holds
//    it while the single memory write port clears the new bottom row (80 cells).
//  - Reset: cursor goes home, color becomes 0x07 and the whole screen is
//    cleared to blanks, one cell per cycle over ROWS*COLUMNS = 2000 cells,
//    while s_tready stays low.
//  - A stalled receiver holds the output word; the two-entry queue keeps
//    accepting words until it fills, then s_tready drops.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_column, [23:20] zero
  input  logic [tcw_pkg::S_DATA_W-1:0]  s_tdata,
  // [0] operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [7:0] cell_char, [15:8] cell_color, [20:16] cursor_row_now,
  // [27:21] cursor_column_now, [28] scrolled, [31:29] zero
  output logic [tcw_pkg::M_DATA_W-1:0]  m_tdata,
  input  logic                          cfg_wr_en,
  input  logic [7:0]                    cfg_wr_data
);
  import tcw_pkg::*;

  back_stat_t stat;
  logic       q_valid;
  cmd_t       q_cmd;

  tcw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .stat     (stat),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  tcw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

/* rtl/core/tcw_checker.sv */
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg.
module tcw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tcw_pkg::M_DATA_W-1:0]  m_tdata
);
  import tcw_pkg::*;

  // reset starts the clearing sweep: nothing accepted, nothing offered
  a_reset: assert property (@(posedge clk) rst |=> !s_tready && !m_tvalid)
    else $error("tcw: ready or valid high right after reset");

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("tcw: output word changed while stalled");

  // a scroll always leaves the cursor at column 0 of the last row
  a_scroll: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[28] |->
      m_tdata[27:21] == 7'd0 && 16'(m_tdata[20:16]) == 16'((ROWS - 1) % 32))
    else $error("tcw: scroll reported with cursor off the last row start");

  // cursor stays on screen
  a_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> 16'(m_tdata[27:21]) < 16'(COLUMNS) && 16'(m_tdata[20:16]) < 16'(ROWS))
    else $error("tcw: cursor outside the screen");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* test/text_console_writer_test.sv */
// Self-checking testbench for the text console writer stream block.
// Keeps its own copy of screen, cursor and color, predicts each output word and
// compares it field by field. Depends only on tcw_pkg and text_console_writer.
`timescale 1ns / 100ps

module text_console_writer_test;
  import tcw_pkg::*;

  // one output word, fields from the bottom of the console result up
  typedef struct packed {
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             scrolled;
  } console_word_t;

  localparam int GAP_MAX   = 19;
  localparam int SETTLE    = COLUMNS + 20;  // idle margin after the last word
  localparam int HOLD_LONG = 400;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [7:0]           cfg_wr_data = '0;

  // mirror of the console
  logic [15:0]   screen_mirror [CELL_COUNT];
  int            cursor_row;
  int            cursor_col;
  logic [7:0]    color_mirror;

  console_word_t awaited_words [$];
  int            error_count = 0;
  bit            src_gaps_on = 1'b1;
  bit            sink_stalls_on = 1'b1;
  int            hold_off_cycles = 0;

  text_console_writer u_dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // cursor to column 0 of the next row; scrolls the mirror when past the bottom
  function automatic bit line_feed();
    cursor_col = 0;
    cursor_row++;
    if (cursor_row < ROWS) return 1'b0;
    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
      screen_mirror[i] = screen_mirror[i + COLUMNS];
    for (int x = 0; x < COLUMNS; x++)
      screen_mirror[(ROWS - 1) * COLUMNS + x] = {color_mirror, CH_BLANK};
    cursor_row = ROWS - 1;
    return 1'b1;
  endfunction

  // applies one word to the mirror and returns the output word it should give
  function automatic console_word_t console_step(input logic op, input logic [7:0] ch,
                                                 input logic [4:0] rr, input logic [6:0] rc);
    console_word_t r;
    logic [15:0] entry;
    r = '0;
    if (op == OP_READ) begin
      if (int'(rr) < ROWS && int'(rc) < COLUMNS) begin
        entry = screen_mirror[int'(rr) * COLUMNS + int'(rc)];
        r.cell_char  = entry[7:0];
        r.cell_color = entry[15:8];
      end
    end else if (ch == CH_NEWLINE) begin
      r.scrolled = line_feed();
    end else if (ch == CH_RETURN) begin
      cursor_col = 0;
    end else if (ch == CH_TAB) begin
      cursor_col = (cursor_col + 8) & ~7;
      if (cursor_col >= COLUMNS) r.scrolled = line_feed();
    end else begin
      screen_mirror[cursor_row * COLUMNS + cursor_col] = {color_mirror, ch};
      cursor_col++;
      if (cursor_col >= COLUMNS) r.scrolled = line_feed();
    end
    r.row = ROW_W'(cursor_row);
    r.col = COL_W'(cursor_col);
    return r;
  endfunction

  // offers one word, optionally after a random gap, and predicts it on acceptance
  task automatic send_word(input logic op, input logic [7:0] ch,
                           input logic [4:0] rr, input logic [6:0] rc);
    if (src_gaps_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0, rc, rr, ch};
    do begin
      @(posedge clk);
    end while (!s_tready);
    awaited_words.push_back(console_step(op, ch, rr, rc));
  endtask

  // stops offering, waits for every awaited word and lets a scroll clear finish
  task automatic drain();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (awaited_words.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    if (awaited_words.size() != 0) begin
      error_count += awaited_words.size();
      $display("ERROR: %0d output words never arrived", awaited_words.size());
      awaited_words.delete();
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_text_color(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    color_mirror = value;
  endtask

  // mostly text with control codes; reads aim at the cursor row, the bottom row or any cell
  task automatic send_random_word(input int newline_pct);
    int pick;
    logic op;
    logic [7:0] ch;
    logic [4:0] rr;
    logic [6:0] rc;
    op = OP_PUT;
    ch = 8'($urandom_range(0, 255));
    rr = 5'($urandom_range(0, 31));
    rc = 7'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      op = OP_READ;
      pick = $urandom_range(0, 99);
      if (pick >= 10) begin
        rc = 7'($urandom_range(0, COLUMNS - 1));
        if (pick < 40) rr = 5'(ROWS - 1);
        else if (pick < 70) rr = 5'(cursor_row);
        else rr = 5'($urandom_range(0, ROWS - 1));
      end
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) ch = CH_NEWLINE;
      else if (pick < newline_pct + 5) ch = CH_RETURN;
      else if (pick < newline_pct + 13) ch = CH_TAB;
    end
    send_word(op, ch, rr, rc);
  endtask

  // reset screen contents, range checks of reads, each control code, tab wrap
  task automatic test_directed();
    send_word(OP_READ, 8'h00, 5'd0, 7'd0);
    send_word(OP_READ, 8'hFF, 5'd24, 7'd79);
    send_word(OP_READ, 8'h00, 5'd31, 7'd127);
    send_word(OP_READ, 8'h00, 5'd25, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd80);
    send_word(OP_PUT, 8'h48, 5'd31, 7'd127);
    send_word(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_word(OP_PUT, CH_RETURN, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd1);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_PUT, 8'h78, 5'd0, 7'd0);
    send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_PUT, CH_NEWLINE, 5'd0, 7'd0);
    // tabs up to the last stop, then one more wraps to the next line
    repeat (10) send_word(OP_PUT, CH_TAB, 5'd0, 7'd0);
    send_word(OP_READ, 8'h00, 5'd0, 7'd9);
  endtask

  task automatic test_random_text(input logic [7:0] color, input int count,
                                  input int newline_pct);
    drain();
    write_text_color(color);
    repeat (count) send_random_word(newline_pct);
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    drain();
    src_gaps_on = 1'b0;
    hold_off_cycles = HOLD_LONG;
    repeat (40) send_random_word(15);
    src_gaps_on = 1'b1;
  endtask

  // no idling on either side for the last stretch
  task automatic test_full_rate();
    drain();
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    write_text_color(8'($urandom_range(0, 255)));
    repeat (250) send_random_word(12);
  endtask

  // receiver ready pattern: long hold on request, else random stall bursts
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else if (sink_stalls_on && $urandom_range(0, 9) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // compare each accepted output word with the oldest prediction
  always @(posedge clk) begin
    console_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{cell_char: m_tdata[7:0], cell_color: m_tdata[15:8], row: m_tdata[20:16],
              col: m_tdata[27:21], scrolled: m_tdata[28]};
      if (awaited_words.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("ERROR: unexpected output word %h", m_tdata);
      end else begin
        want = awaited_words.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= 10)
            $display({"ERROR: char %h/%h color %h/%h row %0d/%0d col %0d/%0d",
                      " scroll %b/%b (exp/got)"},
                     want.cell_char, got.cell_char, want.cell_color, got.cell_color,
                     want.row, got.row, want.col, got.col, want.scrolled, got.scrolled);
        end
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : main_sequence
    for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = {RESET_COLOR, CH_BLANK};
    cursor_row   = 0;
    cursor_col   = 0;
    color_mirror = RESET_COLOR;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_text(RESET_COLOR, 300, 12);
    test_random_text(8'h00, 300, 3);
    test_random_text(8'hFF, 300, 20);
    test_backpressure();
    test_random_text(8'($urandom_range(0, 255)), 300, 10);
    test_full_rate();
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
